// ===== src/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared widths, curve constants, handshake structs and the gamma table
// builder for the pixel tone map, gamma and quantize block.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned GammaBitsDef = 10;

  localparam int unsigned SumW   = 40;
  localparam int unsigned CountW = 16;
  localparam int unsigned PixW   = 8;

  localparam logic [CountW-1:0] CountReset = 16'd200;
  localparam logic [CountW-1:0] CountOne   = 16'd1;
  localparam logic [PixW-1:0]   PixMax     = 8'hFF;

  // averaged radiance, Q24, saturated at 32.0
  localparam int unsigned AvgW = 30;
  localparam logic [AvgW-1:0] AvgMax = 30'h2000_0000;

  localparam int unsigned KW    = 18;
  localparam int unsigned ProdW = AvgW + CountW;
  localparam int unsigned XW    = 29;
  localparam int unsigned P1W   = KW + XW;
  localparam int unsigned TW    = 24;
  localparam int unsigned NumW  = TW + XW;
  localparam int unsigned DenW  = NumW + 1;
  localparam int unsigned DdW   = DenW - 16;
  localparam int unsigned YW    = 16;

  localparam logic [CountW-1:0] KExposure = 16'd55706;
  localparam logic [ProdW-1:0]  XRound    = ProdW'(32768);
  localparam logic [KW-1:0]     KA        = 18'd164495;
  localparam logic [KW-1:0]     KC        = 18'd159252;
  localparam logic [P1W:0]      T1Bias    = (P1W + 1)'(1966) << 24;
  localparam logic [P1W:0]      T2Bias    = (P1W + 1)'(38666) << 24;
  localparam logic [DenW-1:0]   DenBias   = DenW'(9175) << 24;

  // front, divider, four arithmetic stages, divider, table read
  localparam int unsigned LaneLat = AvgW + YW + 6;

  localparam int unsigned LutMaxBits = PixW * 4096;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } ptm_rgb_t;

  typedef struct packed {
    logic     valid;
    logic     invalid;
    ptm_rgb_t pix;
  } ptm_res_t;

  typedef struct packed {
    logic advance;
    logic holding;
  } ptm_flow_t;

  // entry i: largest k with (k/256)^11 <= (i/2^g)^5, all in Q32
  function automatic logic [LutMaxBits-1:0] gamma_table(input int unsigned g_bits);
    logic [63:0]           pow11 [256];
    logic [63:0]           base;
    logic [63:0]           acc;
    logic [7:0]            k;
    logic [LutMaxBits-1:0] tbl;
    tbl = '0;
    k   = '0;
    for (int i = 0; i < 256; i++) begin
      base = 64'(i) << 24;
      acc  = base;
      for (int j = 1; j < 11; j++) begin
        acc = (acc * base) >> 32;
      end
      pow11[8'(i)] = acc;
    end
    for (int i = 0; i < (1 << g_bits); i++) begin
      base = 64'(i) << (32 - g_bits);
      acc  = base;
      for (int j = 1; j < 5; j++) begin
        acc = (acc * base) >> 32;
      end
      while (k < 8'd255 && pow11[8'(k + 8'd1)] <= acc) begin
        k = k + 8'd1;
      end
      tbl[i*PixW +: PixW] = k;
    end
    return tbl;
  endfunction

endpackage

// ===== src/pixel_tone_map_gamma_quantize.sv =====
// ----------------------------------------------------------------------------
// pixel_tone_map_gamma_quantize
// Turns one pixel's accumulated radiance sums into 8-bit display values:
// average, exposure, filmic curve, gamma table and quantize.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i/in_ready_o carries red/green/blue sums and the
//   invalid flag; output channel out_valid_o/out_ready_i carries the 8-bit
//   red/green/blue values, one output transaction per input transaction.
//   sample_count is written through cfg_we_i/cfg_wdata_i while idle; zero
//   acts as one.
//   three lanes run the channels side by side, each a 52-stage pipeline
//   (30 stages of the average divider, 16 of the curve divider, front,
//   four arithmetic stages and the table read); the merge stage adds the
//   output register. One pixel enters per cycle unless the pipeline is frozen.
//   when the receiver stalls, one more result parks in a skid entry and the
//   whole pipeline then freezes with in_ready_o low until the output drains.
//   reset clears the valid pipeline and output flags and sets sample_count
//   to 200.
// ----------------------------------------------------------------------------
module pixel_tone_map_gamma_quantize #(
  parameter int unsigned FRAC_BITS        = ptm_pkg::FracBitsDef,
  parameter int unsigned GAMMA_TABLE_BITS = ptm_pkg::GammaBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ptm_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ptm_pkg::SumW-1:0]    red_sum_i,
  input  logic [ptm_pkg::SumW-1:0]    green_sum_i,
  input  logic [ptm_pkg::SumW-1:0]    blue_sum_i,
  input  logic                        sample_invalid_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ptm_pkg::PixW-1:0]    red_out_o,
  output logic [ptm_pkg::PixW-1:0]    green_out_o,
  output logic [ptm_pkg::PixW-1:0]    blue_out_o
);
  import ptm_pkg::*;

  logic [CountW-1:0] sample_count_q;
  logic [CountW-1:0] divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CountReset;
    end else if (cfg_we_i) begin
      sample_count_q <= cfg_wdata_i;
    end
  end

  assign divisor = (sample_count_q == '0) ? CountOne : sample_count_q;

  ptm_flow_t          flow;
  logic               en;
  logic [LaneLat-1:0] vld_q;
  logic [LaneLat-1:0] inv_q;

  assign en         = flow.advance;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LaneLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q <= {inv_q[LaneLat-2:0], sample_invalid_i};
    end
  end

  ptm_res_t res;

  ptm_lane #(
    .FRAC_BITS        (FRAC_BITS),
    .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
  ) u_lane_red (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (red_sum_i),
    .divisor_i (divisor),
    .pix_o     (res.pix.red)
  );

  ptm_lane #(
    .FRAC_BITS        (FRAC_BITS),
    .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
  ) u_lane_green (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (green_sum_i),
    .divisor_i (divisor),
    .pix_o     (res.pix.green)
  );

  ptm_lane #(
    .FRAC_BITS        (FRAC_BITS),
    .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
  ) u_lane_blue (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (blue_sum_i),
    .divisor_i (divisor),
    .pix_o     (res.pix.blue)
  );

  assign res.valid   = vld_q[LaneLat-1];
  assign res.invalid = inv_q[LaneLat-1];

  ptm_rgb_t out_pix;

  ptm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .pix_o       (out_pix),
    .flow_o      (flow)
  );

  assign red_out_o   = out_pix.red;
  assign green_out_o = out_pix.green;
  assign blue_out_o  = out_pix.blue;

`ifndef SYNTHESIS
  // pipeline only freezes while a result sits in the output register
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("pipeline frozen with empty output");

  // freezing starts only after the receiver held off a valid result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(flow.holding))
    else $error("pipeline froze without an output stall");

  // a drained output releases the skid entry at once
  a_stall_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !in_ready_o) |=> in_ready_o)
    else $error("pipeline stayed frozen after output transaction");
`endif

endmodule

// ===== src/ptm_lane.sv =====
// ----------------------------------------------------------------------------
// ptm_lane
// One color channel: pipelined average divider, exposure, filmic curve,
// pipelined curve divider and registered gamma table read.
// ----------------------------------------------------------------------------
module ptm_lane #(
  parameter int unsigned FRAC_BITS        = ptm_pkg::FracBitsDef,
  parameter int unsigned GAMMA_TABLE_BITS = ptm_pkg::GammaBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ptm_pkg::SumW-1:0]    sum_i,
  input  logic [ptm_pkg::CountW-1:0]  divisor_i,
  output logic [ptm_pkg::PixW-1:0]    pix_o
);
  import ptm_pkg::*;

  localparam int unsigned DivW = SumW + 24 - FRAC_BITS;
  localparam int unsigned HiW  = DivW - AvgW;
  localparam int unsigned CmpW = (HiW > CountW) ? HiW : CountW;
  localparam logic [LutMaxBits-1:0] GammaAll = gamma_table(GAMMA_TABLE_BITS);

  // front: scale to Q24, split off the high bits that decide saturation and seed the remainder
  logic [DivW-1:0] dividend;
  logic [CmpW-1:0] hi_ext;
  logic [CmpW-1:0] div_ext;

  assign dividend = DivW'(sum_i) << (24 - FRAC_BITS);
  assign hi_ext   = CmpW'(dividend[DivW-1:AvgW]);
  assign div_ext  = CmpW'(divisor_i);

  logic [CountW-1:0] r1_q   [AvgW];
  logic [AvgW-1:0]   lq1_q  [AvgW+1];
  logic              ovf1_q [AvgW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q[0]   <= hi_ext[CountW-1:0];
      lq1_q[0]  <= dividend[AvgW-1:0];
      ovf1_q[0] <= (hi_ext >= div_ext);
    end
  end

  // one quotient bit per stage; dividend bits leave the top as quotient enters
  for (genvar k = 0; k < AvgW; k++) begin : g_div1
    logic [CountW:0] trial;
    logic            take;
    assign trial = {r1_q[k], lq1_q[k][AvgW-1]};
    assign take  = (trial >= {1'b0, divisor_i});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lq1_q[k+1]  <= {lq1_q[k][AvgW-2:0], take};
        ovf1_q[k+1] <= ovf1_q[k];
      end
    end
    if (k < AvgW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r1_q[k+1] <= take ? CountW'(trial - {1'b0, divisor_i}) : trial[CountW-1:0];
        end
      end
    end
  end

  // exposure and curve
  logic [AvgW-1:0]  avg;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] x_round;
  logic [XW-1:0]    x;
  logic [XW-1:0]    x_q;
  logic [P1W-1:0]   p1_q;
  logic [P1W-1:0]   p2_q;
  logic [P1W:0]     s1;
  logic [P1W:0]     s2;
  logic [TW-1:0]    t1;
  logic [TW-1:0]    t2;
  logic [NumW-1:0]  num_q;
  logic [NumW-1:0]  pt_q;
  logic [DenW-1:0]  den;
  logic [DdW-1:0]   dd;
  logic             sat;

  assign avg = (ovf1_q[AvgW] || lq1_q[AvgW] > AvgMax) ? AvgMax : lq1_q[AvgW];

  assign x_round = prod_q + XRound;
  assign x       = x_round[XW+15:16];

  assign s1 = {1'b0, p1_q} + T1Bias;
  assign s2 = {1'b0, p2_q} + T2Bias;
  assign t1 = s1[TW+23:24];
  assign t2 = s2[TW+23:24];

  assign den = DenW'(pt_q) + DenBias;
  assign dd  = den[DenW-1:16];
  assign sat = ({1'b0, num_q} >= {dd, 16'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(avg) * ProdW'(KExposure);
      x_q    <= x;
      p1_q   <= P1W'(x) * P1W'(KA);
      p2_q   <= P1W'(x) * P1W'(KC);
      num_q  <= NumW'(t1) * NumW'(x_q);
      pt_q   <= NumW'(t2) * NumW'(x_q);
    end
  end

  // curve divider, Q16 quotient, quotient of 1.0 or more is flagged up front
  logic [DdW-1:0] r2_q   [YW];
  logic [DdW-1:0] dd2_q  [YW];
  logic [YW-1:0]  lq2_q  [YW+1];
  logic           sat2_q [YW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q[0]   <= DdW'(num_q[NumW-1:16]);
      dd2_q[0]  <= dd;
      lq2_q[0]  <= num_q[15:0];
      sat2_q[0] <= sat;
    end
  end

  for (genvar k = 0; k < YW; k++) begin : g_div2
    logic [DdW:0] trial;
    logic         take;
    assign trial = {r2_q[k], lq2_q[k][YW-1]};
    assign take  = (trial >= {1'b0, dd2_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lq2_q[k+1]  <= {lq2_q[k][YW-2:0], take};
        sat2_q[k+1] <= sat2_q[k];
      end
    end
    if (k < YW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r2_q[k+1]  <= take ? DdW'(trial - {1'b0, dd2_q[k]}) : trial[DdW-1:0];
          dd2_q[k+1] <= dd2_q[k];
        end
      end
    end
  end

  // gamma table read
  logic [GAMMA_TABLE_BITS-1:0] idx;
  logic [PixW-1:0]             pix_q;

  assign idx = lq2_q[YW][YW-1 -: GAMMA_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= sat2_q[YW] ? PixMax : GammaAll[{idx, 3'b000} +: PixW];
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== src/ptm_merge.sv =====
// ----------------------------------------------------------------------------
// ptm_merge
// Joins the three lane results, blanks invalid pixels, and holds them in an
// output register backed by one skid entry.
// ----------------------------------------------------------------------------
module ptm_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptm_pkg::ptm_res_t  res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output ptm_pkg::ptm_rgb_t  pix_o,
  output ptm_pkg::ptm_flow_t flow_o
);
  import ptm_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  ptm_rgb_t out_pix_q, out_pix_d;
  ptm_rgb_t skid_pix_q, skid_pix_d;
  ptm_rgb_t rgb_in;
  logic     advance;
  logic     arrive;
  logic     take;

  assign rgb_in  = res_i.invalid ? '0 : res_i.pix;
  assign advance = ~skid_valid_q;
  assign arrive  = res_i.valid & advance;
  assign take    = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_pix_d    = out_pix_q;
    skid_pix_d   = skid_pix_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pix_d    = skid_pix_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = arrive;
        if (arrive) begin
          out_pix_d = rgb_in;
        end
      end
    end else if (arrive) begin
      // output held, park the new transaction
      skid_valid_d = 1'b1;
      skid_pix_d   = rgb_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    skid_pix_q <= skid_pix_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pix_o          = out_pix_q;
  assign flow_o.advance = advance;
  assign flow_o.holding = out_valid_q & ~out_ready_i;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the pixel tone map, gamma and quantize block. Sends pixels
// of radiance sums under several sample count settings, predicts each 8-bit
// RGB output with a fixed-point model of average, exposure, filmic curve and
// gamma table, and checks every output transaction in order, with both sides
// idling and stalling at random in the random sample count phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptm_pkg::*;

  localparam int unsigned TbFrac   = FracBitsDef;
  localparam int unsigned TbGamma  = GammaBitsDef;
  localparam int unsigned LutDepth = 1 << TbGamma;

  // curve constants, Q16; AvgCeiling is 32.0 in Q24
  localparam logic [63:0] Exposure85 = 64'd55706;
  localparam logic [63:0] CurveA     = 64'd164495;
  localparam logic [63:0] CurveB     = 64'd1966;
  localparam logic [63:0] CurveC     = 64'd159252;
  localparam logic [63:0] CurveD     = 64'd38666;
  localparam logic [63:0] CurveE     = 64'd9175;
  localparam logic [63:0] AvgCeiling = 64'd1 << 29;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [SumW-1:0]   red_sum_i;
  logic [SumW-1:0]   green_sum_i;
  logic [SumW-1:0]   blue_sum_i;
  logic              sample_invalid_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PixW-1:0]   red_out_o;
  logic [PixW-1:0]   green_out_o;
  logic [PixW-1:0]   blue_out_o;

  logic [PixW-1:0]   gamma_lut [LutDepth];
  logic [CountW-1:0] divisor_setting;
  ptm_rgb_t          pix_expected_q [$];

  bit          tx_idle_on;
  bit          rx_stall_on;
  int unsigned fail_count;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned settings_used;

  pixel_tone_map_gamma_quantize #(
    .FRAC_BITS        (TbFrac),
    .GAMMA_TABLE_BITS (TbGamma)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .red_sum_i        (red_sum_i),
    .green_sum_i      (green_sum_i),
    .blue_sum_i       (blue_sum_i),
    .sample_invalid_i (sample_invalid_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .red_out_o        (red_out_o),
    .green_out_o      (green_out_o),
    .blue_out_o       (blue_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] q32_power(input logic [63:0] base, input int unsigned n);
    logic [63:0] acc;
    acc = base;
    for (int j = 1; j < n; j++) begin
      acc = (acc * base) >> 32;
    end
    return acc;
  endfunction

  // code k is kept while (k/256)^11 stays at or below the bin's low edge to the 5th
  task automatic build_gamma_lut();
    logic [63:0] code_pow [256];
    logic [63:0] bin_pow;
    int unsigned code;
    code = 0;
    for (int k = 0; k < 256; k++) begin
      code_pow[8'(k)] = q32_power(64'(k) << 24, 11);
    end
    for (int i = 0; i < LutDepth; i++) begin
      bin_pow = q32_power(64'(i) << (32 - TbGamma), 5);
      while (code < 255 && code_pow[8'(code + 1)] <= bin_pow) code++;
      gamma_lut[TbGamma'(i)] = PixW'(code);
    end
  endtask

  function automatic logic [PixW-1:0] tone_map_channel(input logic [SumW-1:0] sum,
                                                      input logic [CountW-1:0] count);
    logic [63:0] n;
    logic [63:0] avg;
    logic [63:0] x;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] y;
    n   = (count == '0) ? 64'd1 : 64'(count);
    avg = (64'(sum) << (24 - TbFrac)) / n;
    if (avg > AvgCeiling) avg = AvgCeiling;
    x   = (avg * Exposure85 + 64'd32768) >> 16;
    t1  = (CurveA * x + (CurveB << 24)) >> 24;
    num = t1 * x;
    t2  = (CurveC * x + (CurveD << 24)) >> 24;
    den = t2 * x + (CurveE << 24);
    y   = num / (den >> 16);
    if (y >= 64'd65536) return PixMax;
    return gamma_lut[TbGamma'(y >> (16 - TbGamma))];
  endfunction

  function automatic ptm_rgb_t predict_pixel(input logic [SumW-1:0] r, input logic [SumW-1:0] g,
                                             input logic [SumW-1:0] b, input logic inv);
    ptm_rgb_t pix;
    pix = '0;
    if (!inv) begin
      pix.red   = tone_map_channel(r, divisor_setting);
      pix.green = tone_map_channel(g, divisor_setting);
      pix.blue  = tone_map_channel(b, divisor_setting);
    end
    return pix;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly averages in the curve's working range, some log-spread, some extremes
  function automatic logic [SumW-1:0] rand_radiance(input logic [CountW-1:0] count);
    logic [63:0] raw;
    logic [63:0] span;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    span = ((count == '0) ? 64'd1 : 64'(count)) * (64'd12 << TbFrac);
    pick = $urandom_range(0, 99);
    if (pick < 65) return SumW'(raw % (span + 64'd1));
    if (pick < 90) return SumW'(raw >> $urandom_range(24, 63));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return SumW'(1) << $urandom_range(0, SumW - 1);
      default: return SumW'(raw);
    endcase
  endfunction

  // called at a clock edge; returns at the edge where the pixel is accepted
  task automatic send_pixel(input logic [SumW-1:0] r, input logic [SumW-1:0] g,
                            input logic [SumW-1:0] b, input logic inv);
    int unsigned gap;
    ptm_rgb_t    pix;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix = predict_pixel(r, g, b, inv);
    in_valid_i       <= 1'b1;
    red_sum_i        <= r;
    green_sum_i      <= g;
    blue_sum_i       <= b;
    sample_invalid_i <= inv;
    do @(posedge clk_i); while (!in_ready_o);
    pix_expected_q = {pix_expected_q, pix};
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_radiance(divisor_setting), rand_radiance(divisor_setting),
               rand_radiance(divisor_setting), $urandom_range(0, 19) == 0);
  endtask

  // hold off the sender until every predicted pixel has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pix_expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_sample_count(input logic [CountW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    divisor_setting = value;
    settings_used++;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_count();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    send_pixel('0, '0, '0, 1'b0);
    send_pixel('1, '1, '1, 1'b0);
    send_pixel('1, 40'd13107200, 40'd1, 1'b1);      // invalid forces black
    send_pixel('1, '1, '1, 1'b1);
    send_pixel(40'd13107200, 40'd1, 40'd65536, 1'b0);   // average 1.0
    send_pixel(40'd111000000, 40'd111650000, 40'd112500000, 1'b0); // curve crosses 1.0
    send_pixel(40'd419430400, 40'd419430656, 40'd419430399, 1'b0); // average clamp
    send_pixel(40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'h80_0000_0000, 1'b0);
    send_pixel(40'd1310720, 40'd3276800, 40'd6553600, 1'b0);
    settings_used++;
  endtask

  task automatic test_count_extremes();
    write_sample_count('0);   // zero divides as one
    send_pixel(40'd1, 40'd65536, '1, 1'b0);
    send_pixel(40'd32768, 40'd500000, 40'd256, 1'b0);
    send_pixel('1, '0, 40'd1, 1'b1);
    write_sample_count(CountOne);
    send_pixel(40'd1, 40'd65536, '1, 1'b0);
    send_pixel(40'd32768, 40'd500000, 40'd256, 1'b0);
    write_sample_count('1);
    send_pixel('1, '0, 40'd1, 1'b0);
    send_pixel(40'd4294901760, 40'd36000000000, 40'd500000000000, 1'b0);
    send_pixel(40'h00_FFFF_FFFF, 40'hF0_0000_0000, 40'h0F_0F0F_0F0F, 1'b0);
  endtask

  task automatic test_back_to_back();
    write_sample_count(CountReset);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    repeat (150) send_random_pixel();
  endtask

  task automatic test_random_counts();
    logic [CountW-1:0] phase_counts [8];
    phase_counts = '{16'd1, 16'd65535, 16'd7, 16'd200, 16'd0, 16'd4096,
                     CountW'($urandom), CountW'($urandom_range(2, 64))};
    foreach (phase_counts[p]) begin
      write_sample_count(phase_counts[p]);
      for (int i = 0; i < 125; i++) begin
        if (i % 25 == 0) begin
          tx_idle_on  = $urandom_range(0, 3) != 0;
          rx_stall_on = $urandom_range(0, 3) != 0;
        end
        if ($urandom_range(0, 99) == 0) drain_results();
        send_random_pixel();
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (1 + idle_len()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ptm_rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pix_expected_q.size() == 0) begin
        $error("output transaction with no pixel outstanding");
        fail_count++;
      end else begin
        want = pix_expected_q.pop_front();
        pixels_checked++;
        if (red_out_o !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out_o);
          fail_count++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out_o);
          fail_count++;
        end
        if (blue_out_o !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    red_sum_i        <= '0;
    green_sum_i      <= '0;
    blue_sum_i       <= '0;
    sample_invalid_i <= 1'b0;
    out_ready_i      <= 1'b0;
    tx_idle_on      = 1'b0;
    rx_stall_on     = 1'b0;
    fail_count      = 0;
    pixels_sent     = 0;
    pixels_checked  = 0;
    settings_used   = 0;
    divisor_setting = CountReset;
    build_gamma_lut();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_count();
    test_count_extremes();
    test_back_to_back();
    test_random_counts();

    drain_results();
    // catch any stray output after the last pixel
    repeat (LaneLat + 8) @(posedge clk_i);
    $display("covered %0d pixels under %0d sample count settings, %0d outputs compared",
             pixels_sent, settings_used, pixels_checked);
    $display("including zero and full-scale divisors, invalid pixels and clamped averages");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== pixel_tone_map_gamma_quantize.f =====
src/ptm_pkg.sv
src/ptm_lane.sv
src/ptm_merge.sv
src/pixel_tone_map_gamma_quantize.sv
dv/tb_top.sv
